/* rtl/kmp_pkg.sv */
`default_nettype none

package kmp_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 256;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

  localparam logic STAT_MATCH    = 1'b0;
  localparam logic STAT_OVERFLOW = 1'b1;

endpackage

`default_nettype wire

/* rtl/kmp_in_if.sv */
`default_nettype none

interface kmp_in_if import kmp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

`default_nettype wire

/* rtl/kmp_out_if.sv */
`default_nettype none

interface kmp_out_if import kmp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               status;
  logic [COUNT_W-1:0] match_position;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, output status, output match_position, output match_count,
                  input ready);
  modport sink   (input valid, input status, input match_position, input match_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/kmp_stream_matcher_top.sv */
`default_nettype none

// Channel  Role  Payload                                   Transfer
// item     sink  command[1:0], byte_value[7:0]             valid && ready
// result   src   status, match_position[31:0], match_count valid && ready
//
// Clear, ignored commands, the first pattern byte and text bytes against an empty pattern
// are handled in the idle state; a dropped pattern byte goes through the emit state.
// Other pattern and text bytes go through the compare state, once more for each
// failure-table fallback; the pattern store and failure table each have one read port
// with a registered read, and one compare is made per cycle. A match also passes through the emit state.
// A result waits in an output register; the block stalls only when a second result
// is ready while the first is still untaken. Reset is synchronous and needs no sweep.

module kmp_stream_matcher_top import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire        clk,
  input  wire        rst,
  kmp_in_if.sink     item,
  kmp_out_if.source  result
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_EMIT} state_t;

  state_t              state;
  logic [LW-1:0]       plen;
  logic [LW-1:0]       bpl;
  logic [LW-1:0]       mlen;
  logic [LW-1:0]       last_fail;
  logic [COUNT_W-1:0]  text_pos;
  logic [COUNT_W-1:0]  found_count;
  logic [LW-1:0]       k;
  logic                is_text;
  logic [BYTE_W-1:0]   cur_byte;
  logic                res_status;
  logic [COUNT_W-1:0]  res_pos;
  logic [COUNT_W-1:0]  res_count;
  logic                out_valid;
  logic                out_status;
  logic [COUNT_W-1:0]  out_pos;
  logic [COUNT_W-1:0]  out_count;

  logic [BYTE_W-1:0]   pstore [MAX_PATTERN];
  logic [LW-1:0]       ftable [MAX_PATTERN];
  logic [BYTE_W-1:0]   p_rdata;
  logic [LW-1:0]       f_rdata;

  logic                accept;
  logic [LW-1:0]       rd_k;
  logic [LW-1:0]       rd_km1;
  logic                fall;
  logic                hit;
  logic [LW-1:0]       k_next;
  logic                p_we;
  logic                f_we;
  logic [IW-1:0]       f_waddr;
  logic [LW-1:0]       f_wdata;
  logic                slot_free;
  logic                load_out;
  logic [COUNT_W-1:0]  count_inc;

  assign accept    = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);
  assign slot_free = !out_valid || result.ready;
  assign load_out  = (state == ST_EMIT) && slot_free;
  assign count_inc = (found_count != COUNT_SAT) ? found_count + COUNT_W'(1) : found_count;

  assign fall   = (k != '0) && (k < plen) && (p_rdata != cur_byte);
  assign hit    = (k < plen) && (p_rdata == cur_byte);
  assign k_next = hit ? k + LW'(1) : k;

  always_comb begin
    if (state == ST_IDLE) begin
      rd_k = (item.command == CMD_TEXT) ? mlen : bpl;
    end else begin
      rd_k = f_rdata;
    end
    rd_km1 = rd_k - LW'(1);
  end

  assign p_we = accept && (item.command == CMD_PATTERN) && (plen != LEN_MAX);

  always_comb begin
    f_we    = 1'b0;
    f_waddr = plen[IW-1:0];
    f_wdata = k_next;
    if (p_we && (plen == '0)) begin
      f_we    = 1'b1;
      f_wdata = '0;
    end else if ((state == ST_CMP) && !fall && !is_text) begin
      f_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pstore[plen[IW-1:0]] <= item.byte_value;
    end
    p_rdata <= pstore[rd_k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      ftable[f_waddr] <= f_wdata;
    end
    f_rdata <= ftable[rd_km1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      plen        <= '0;
      bpl         <= '0;
      mlen        <= '0;
      last_fail   <= '0;
      text_pos    <= '0;
      found_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            k        <= rd_k;
            cur_byte <= item.byte_value;
            case (item.command)
              CMD_CLEAR: begin
                plen        <= '0;
                bpl         <= '0;
                mlen        <= '0;
                text_pos    <= '0;
                found_count <= '0;
              end
              CMD_PATTERN: begin
                is_text <= 1'b0;
                if (plen == LEN_MAX) begin
                  res_status <= STAT_OVERFLOW;
                  res_pos    <= '0;
                  res_count  <= found_count;
                  state      <= ST_EMIT;
                end else if (plen == '0) begin
                  bpl       <= '0;
                  last_fail <= '0;
                  plen      <= LW'(1);
                end else begin
                  state <= ST_CMP;
                end
              end
              CMD_TEXT: begin
                is_text <= 1'b1;
                res_pos <= text_pos - COUNT_W'(plen) + COUNT_W'(1);
                if (text_pos != COUNT_SAT) begin
                  text_pos <= text_pos + COUNT_W'(1);
                end
                if (plen != '0) begin
                  state <= ST_CMP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CMP: begin
          if (fall) begin
            k <= f_rdata;
          end else if (is_text) begin
            if (k_next == plen) begin
              found_count <= count_inc;
              res_status  <= STAT_MATCH;
              res_count   <= count_inc;
              mlen        <= last_fail;
              state       <= ST_EMIT;
            end else begin
              mlen  <= k_next;
              state <= ST_IDLE;
            end
          end else begin
            bpl       <= k_next;
            last_fail <= k_next;
            plen      <= plen + LW'(1);
            state     <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_status <= res_status;
            out_pos    <= res_pos;
            out_count  <= res_count;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.match_position = out_pos;
  assign result.match_count    = out_count;

  a_k_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (k < plen))
    else $error("prefix length not below pattern length during compare");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (plen <= LEN_MAX) && (mlen <= plen) && (bpl <= plen))
    else $error("length registers out of range");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == STAT_MATCH)) |-> (result.match_count != '0))
    else $error("match reported with zero count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.command == CMD_CLEAR)) |=> ((plen == '0) && (found_count == '0)))
    else $error("clear did not empty the pattern and counters");

endmodule

`default_nettype wire
